>>> rtl/core/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

   // Field widths of the request and response items
   localparam int OP_W     = 3;
   localparam int CLASS_W  = 8;
   localparam int NAME_W   = 32;
   localparam int DIST_W   = 7;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
   localparam logic [OP_W-1:0] OP_POP        = 3'd1;
   localparam logic [OP_W-1:0] OP_OPEN       = 3'd2;
   localparam logic [OP_W-1:0] OP_CLOSE      = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND_LEVEL = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_LEVEL = 2'd3;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_FIND,
      CTRL_CLOSE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // request taken this cycle
      logic find_run;    // search engine active
      logic close_load;  // restore outer level count from level RAM
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_valid;   // response register occupied
      logic find_done;   // search finished this cycle
      logic span_zero;   // requested search span is empty
      logic level_base;  // current level is the base level
   } dp_status_type;

endpackage

>>> rtl/core/sss_ram.sv
`timescale 1ns / 1ps

module sss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sss_ctrl.sv
`timescale 1ns / 1ps

module sss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic [sss_pkg::OP_W-1:0] req_op,
   input  logic                     rsp_tready,
   input  sss_pkg::dp_status_type   status,
   output logic                     req_tready,
   output sss_pkg::dp_cmd_type      cmd
);

   sss_pkg::ctrl_state_type state_ff, state_in;
   logic is_find;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sss_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.accept     = 1'b0;
      cmd.find_run   = 1'b0;
      cmd.close_load = 1'b0;
      is_find        = (req_op == sss_pkg::OP_FIND) || (req_op == sss_pkg::OP_FIND_LEVEL);
      unique case (state_ff)
         sss_pkg::CTRL_IDLE: begin
            // response slot is free now or drains this cycle
            req_tready = !status.rsp_valid || rsp_tready;
            cmd.accept = req_tready && req_tvalid;
            if (cmd.accept) begin
               if (is_find && !status.span_zero) begin
                  state_in = sss_pkg::CTRL_FIND;
               end else if (req_op == sss_pkg::OP_CLOSE && !status.level_base) begin
                  state_in = sss_pkg::CTRL_CLOSE;
               end
            end
         end
         sss_pkg::CTRL_FIND: begin
            cmd.find_run = 1'b1;
            if (status.find_done) begin
               state_in = sss_pkg::CTRL_IDLE;
            end
         end
         sss_pkg::CTRL_CLOSE: begin
            cmd.close_load = 1'b1;
            state_in       = sss_pkg::CTRL_IDLE;
         end
         default: begin
            state_in = sss_pkg::CTRL_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/sss_dp.sv
`timescale 1ns / 1ps

module sss_dp #(
   parameter int STACK_DEPTH = 128,
   parameter int MAX_LEVELS  = 64,
   parameter int NAME_BITS   = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sss_pkg::dp_cmd_type          cmd,
   output sss_pkg::dp_status_type       status,
   input  logic [sss_pkg::OP_W-1:0]     req_op,
   input  logic [sss_pkg::CLASS_W-1:0]  req_key_class,
   input  logic [sss_pkg::NAME_W-1:0]   req_key_name,
   input  logic                         rsp_tready,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [sss_pkg::DIST_W-1:0]   rsp_distance,
   output logic [sss_pkg::STATUS_W-1:0] rsp_status,
   output logic [sss_pkg::DEPTH_W-1:0]  rsp_depth_in_use
);

   localparam int AW        = $clog2(STACK_DEPTH);
   localparam int CW        = $clog2(STACK_DEPTH + 1);
   localparam int LW        = $clog2(MAX_LEVELS);
   localparam int NAME_KEEP = (NAME_BITS < sss_pkg::NAME_W) ? NAME_BITS : sss_pkg::NAME_W;
   localparam int KEY_W     = sss_pkg::CLASS_W + NAME_KEEP;

   // stack and level state
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [LW-1:0] lv_ff, lv_in;

   // search engine
   logic [CW-1:0]    span_ff, span_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff, found_in;
   logic [sss_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic [sss_pkg::STATUS_W-1:0] stat_ff, stat_in;
   logic [sss_pkg::DEPTH_W-1:0]  depth_ff, depth_in;

   // memories
   logic             key_we;
   logic [AW-1:0]    key_raddr;
   logic [KEY_W-1:0] key_rdata;
   logic             lvl_we;
   logic [CW-1:0]    lvl_rdata;

   logic [KEY_W-1:0] req_key;
   logic [CW-1:0]    req_span;
   logic             issuing, hit, last;

   assign req_key  = {req_key_class, req_key_name[NAME_KEEP-1:0]};
   assign req_span = (req_op == sss_pkg::OP_FIND_LEVEL) ? cur_ff : top_ff;
   assign issuing  = issue_ff < span_ff;
   assign hit      = rd_valid_ff && (key_rdata == key_ff);
   assign last     = rd_valid_ff && (rd_idx_ff == span_ff - CW'(1));

   // search walks down from the top entry
   assign key_raddr = AW'(top_ff - CW'(1) - issue_ff);

   sss_ram #(
      .WIDTH (KEY_W),
      .DEPTH (STACK_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (top_ff[AW-1:0]),
      .wr_data (req_key),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   // holds the key count of each enclosing level
   sss_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LEVELS)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lv_ff),
      .wr_data (cur_ff),
      .rd_addr (lv_ff - LW'(1)),
      .rd_data (lvl_rdata)
   );

   always_comb begin
      top_in       = top_ff;
      cur_in       = cur_ff;
      lv_in        = lv_ff;
      span_in      = span_ff;
      issue_in     = issue_ff;
      rd_valid_in  = rd_valid_ff;
      rd_idx_in    = rd_idx_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      dist_in      = dist_ff;
      stat_in      = stat_ff;
      depth_in     = depth_ff;
      key_we       = 1'b0;
      lvl_we       = 1'b0;

      if (cmd.accept) begin
         rsp_valid_in = 1'b1;
         found_in     = 1'b0;
         dist_in      = '0;
         stat_in      = sss_pkg::STAT_OK;
         span_in      = req_span;
         issue_in     = '0;
         rd_valid_in  = 1'b0;
         key_in       = req_key;
         unique case (req_op) inside
            sss_pkg::OP_PUSH: begin
               if (top_ff >= CW'(STACK_DEPTH)) begin
                  stat_in = sss_pkg::STAT_FULL;
               end else begin
                  key_we = 1'b1;
                  top_in = top_ff + CW'(1);
                  cur_in = cur_ff + CW'(1);
               end
            end
            sss_pkg::OP_POP: begin
               if (cur_ff == '0 || top_ff == '0) begin
                  stat_in = sss_pkg::STAT_EMPTY;
               end else begin
                  top_in = top_ff - CW'(1);
                  cur_in = cur_ff - CW'(1);
               end
            end
            sss_pkg::OP_OPEN: begin
               if (lv_ff == LW'(MAX_LEVELS - 1)) begin
                  stat_in = sss_pkg::STAT_LEVEL;
               end else begin
                  lvl_we = 1'b1;
                  lv_in  = lv_ff + LW'(1);
                  cur_in = '0;
               end
            end
            sss_pkg::OP_CLOSE: begin
               if (lv_ff == '0) begin
                  stat_in = sss_pkg::STAT_LEVEL;
               end else begin
                  // outer count is restored in the following cycle
                  top_in = (cur_ff > top_ff) ? '0 : top_ff - cur_ff;
                  lv_in  = lv_ff - LW'(1);
               end
            end
            sss_pkg::OP_FIND, sss_pkg::OP_FIND_LEVEL: begin
               // nonempty search: response comes from the engine
               if (req_span != '0) begin
                  rsp_valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
         depth_in = sss_pkg::DEPTH_W'(top_in);
      end

      if (cmd.close_load) begin
         cur_in = lvl_rdata;
      end

      if (cmd.find_run) begin
         if (issuing) begin
            issue_in = issue_ff + CW'(1);
         end
         rd_valid_in = issuing;
         rd_idx_in   = issue_ff;
         if (hit || last) begin
            rsp_valid_in = 1'b1;
            found_in     = hit;
            dist_in      = hit ? sss_pkg::DIST_W'(rd_idx_ff) : '0;
            stat_in      = sss_pkg::STAT_OK;
            depth_in     = sss_pkg::DEPTH_W'(top_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         cur_ff       <= '0;
         lv_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         cur_ff       <= cur_in;
         lv_ff        <= lv_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff   <= span_in;
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      dist_ff   <= dist_in;
      stat_ff   <= stat_in;
      depth_ff  <= depth_in;
   end

   assign status.rsp_valid  = rsp_valid_ff;
   assign status.find_done  = cmd.find_run && (hit || last);
   assign status.span_zero  = (req_span == '0);
   assign status.level_base = (lv_ff == '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_distance     = dist_ff;
   assign rsp_status       = stat_ff;
   assign rsp_depth_in_use = depth_ff;

endmodule

>>> rtl/core/scoped_symbol_stack_core.sv
// Push, pop, open, close and zero-span finds answer in the cycle after acceptance.
// Throughput: one request per cycle while responses drain; a close of an inner level holds
// off the next request while the outer level count reloads.
// A find walks the key RAM one entry per cycle from the top and holds off requests until
// it answers, on a hit or once the last entry of its span has missed.
// Reset (sync, active high) empties the stack, opens only the base level; key RAM is not
// cleared and only entries below the fill count are ever read.
`timescale 1ns / 1ps

module scoped_symbol_stack_core #(
   parameter int STACK_DEPTH = 128,
   parameter int MAX_LEVELS  = 64,
   parameter int NAME_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] op, [10:3] key_class, [42:11] key_name, [47:43] zero
   input  logic [47:0] req_tdata,

   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] found, [7:1] distance, [9:8] status, [17:10] depth_in_use, [23:18] zero
   output logic [23:0] rsp_tdata
);

   sss_pkg::dp_cmd_type    cmd;
   sss_pkg::dp_status_type status;

   logic [sss_pkg::OP_W-1:0]     req_op;
   logic [sss_pkg::CLASS_W-1:0]  req_key_class;
   logic [sss_pkg::NAME_W-1:0]   req_key_name;
   logic                         rsp_found;
   logic [sss_pkg::DIST_W-1:0]   rsp_distance;
   logic [sss_pkg::STATUS_W-1:0] rsp_status;
   logic [sss_pkg::DEPTH_W-1:0]  rsp_depth_in_use;

   // unpack request fields
   assign req_op        = req_tdata[2:0];
   assign req_key_class = req_tdata[10:3];
   assign req_key_name  = req_tdata[42:11];

   // sequencer: idle / search / level-count reload
   sss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // counters, key and level RAMs, search engine, response register
   sss_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LEVELS  (MAX_LEVELS),
      .NAME_BITS   (NAME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_key_class    (req_key_class),
      .req_key_name     (req_key_name),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_found        (rsp_found),
      .rsp_distance     (rsp_distance),
      .rsp_status       (rsp_status),
      .rsp_depth_in_use (rsp_depth_in_use)
   );

   // pack response fields
   assign rsp_tdata = {6'd0, rsp_depth_in_use, rsp_status, rsp_distance, rsp_found};

endmodule

>>> sim/scoped_symbol_stack_checker.sv
`timescale 1ns / 1ps

module scoped_symbol_stack_checker #(
   parameter int STACK_DEPTH = 128,
   parameter int MAX_LEVELS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,    // [2:0] op, [10:3] key_class, [42:11] key_name
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // [0] found, [7:1] distance, [9:8] status, [17:10] depth
   output int unsigned fail_count,
   output int unsigned answers_owed
);

   // packed to line up with rsp_tdata[17:0]
   typedef struct packed {
      logic [sss_pkg::DEPTH_W-1:0]  depth;
      logic [sss_pkg::STATUS_W-1:0] status;
      logic [sss_pkg::DIST_W-1:0]   distance;
      logic                         found;
   } stack_answer_type;

   stack_answer_type   owed_q[$];
   int unsigned        fails = 0;
   int unsigned        owed_count = 0;
   int unsigned        answers_seen = 0;

   // shadow of the symbol stack
   logic [sss_pkg::CLASS_W-1:0] shadow_cls  [STACK_DEPTH];
   logic [sss_pkg::NAME_W-1:0]  shadow_name [STACK_DEPTH];
   int unsigned                 key_fill;
   int unsigned                 level_keys  [MAX_LEVELS];
   int unsigned                 cur_level;

   assign fail_count   = fails;
   assign answers_owed = owed_count;

   task automatic report_fault(input string msg);
      $display("%0t checker: %s", $time, msg);
      fails++;
   endtask

   // topmost span entries, walking down from the top
   task automatic search_from_top(input int unsigned span,
                                  input logic [sss_pkg::CLASS_W-1:0] cls,
                                  input logic [sss_pkg::NAME_W-1:0] nm, output logic hit,
                                  output int unsigned hit_pos);
      int unsigned lim;
      int unsigned i;
      lim     = (span > key_fill) ? key_fill : span;
      hit     = 1'b0;
      hit_pos = 0;
      for (i = 0; i < lim && !hit; i++) begin
         if (shadow_cls[key_fill-1-i] == cls && shadow_name[key_fill-1-i] == nm) begin
            hit     = 1'b1;
            hit_pos = i;
         end
      end
   endtask

   task automatic apply_request(input logic [sss_pkg::OP_W-1:0] op,
                                input logic [sss_pkg::CLASS_W-1:0] cls,
                                input logic [sss_pkg::NAME_W-1:0] nm,
                                output stack_answer_type ans);
      logic        hit;
      int unsigned hit_pos;
      ans     = '0;
      hit     = 1'b0;
      hit_pos = 0;
      case (op)
         sss_pkg::OP_PUSH: begin
            if (key_fill >= STACK_DEPTH) begin
               ans.status = sss_pkg::STAT_FULL;
            end else begin
               shadow_cls[key_fill]  = cls;
               shadow_name[key_fill] = nm;
               key_fill++;
               level_keys[cur_level]++;
            end
         end
         sss_pkg::OP_POP: begin
            if (level_keys[cur_level] == 0 || key_fill == 0) begin
               ans.status = sss_pkg::STAT_EMPTY;
            end else begin
               key_fill--;
               level_keys[cur_level]--;
            end
         end
         sss_pkg::OP_OPEN: begin
            if (cur_level + 1 >= MAX_LEVELS) begin
               ans.status = sss_pkg::STAT_LEVEL;
            end else begin
               cur_level++;
               level_keys[cur_level] = 0;
            end
         end
         sss_pkg::OP_CLOSE: begin
            if (cur_level == 0) begin
               ans.status = sss_pkg::STAT_LEVEL;
            end else begin
               key_fill = (level_keys[cur_level] > key_fill) ? 0 :
                          key_fill - level_keys[cur_level];
               level_keys[cur_level] = 0;
               cur_level--;
            end
         end
         sss_pkg::OP_FIND: begin
            search_from_top(key_fill, cls, nm, hit, hit_pos);
         end
         sss_pkg::OP_FIND_LEVEL: begin
            search_from_top(level_keys[cur_level], cls, nm, hit, hit_pos);
         end
         default: begin
         end
      endcase
      ans.found    = hit;
      ans.distance = hit ? hit_pos[sss_pkg::DIST_W-1:0] : '0;
      ans.depth    = key_fill[sss_pkg::DEPTH_W-1:0];
   endtask

   always @(posedge clock) begin
      stack_answer_type want;
      stack_answer_type got;
      if (reset) begin
         owed_q.delete();
         key_fill  = 0;
         cur_level = 0;
         foreach (level_keys[i]) level_keys[i] = 0;
      end else begin
         // responses first: one taken at this edge belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            answers_seen++;
            if (owed_q.size() == 0) begin
               report_fault($sformatf("response %0d with no request outstanding",
                                      answers_seen));
            end else begin
               want = owed_q.pop_front();
               got  = rsp_tdata[17:0];
               if (got.found !== want.found)
                  report_fault($sformatf("response %0d found got %0b want %0b",
                                         answers_seen, got.found, want.found));
               if (got.distance !== want.distance)
                  report_fault($sformatf("response %0d distance got %0d want %0d",
                                         answers_seen, got.distance, want.distance));
               if (got.status !== want.status)
                  report_fault($sformatf("response %0d status got %0d want %0d",
                                         answers_seen, got.status, want.status));
               if (got.depth !== want.depth)
                  report_fault($sformatf("response %0d depth_in_use got %0d want %0d",
                                         answers_seen, got.depth, want.depth));
               if (rsp_tdata[23:18] !== 6'b0)
                  report_fault($sformatf("response %0d pad bits got %b",
                                         answers_seen, rsp_tdata[23:18]));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tdata[2:0], req_tdata[10:3], req_tdata[42:11], want);
            owed_q.insert(owed_q.size(), want);
         end
      end
      owed_count = owed_q.size();
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   // Guard: about 1050 requests, each at worst a full 128-entry walk plus stalls.
   localparam int CYCLE_LIMIT    = 1_000_000;
   // Longest answer: a miss over a full stack.
   localparam int DRAIN_CYCLES   = 140;
   localparam int PHASE_REQUESTS = 256;
   // Unused op codes; the block must treat them as no-ops.
   localparam logic [sss_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [sss_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [47:0]        req_tdata  = '0;  // [2:0] op, [10:3] key_class, [42:11] key_name
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [23:0]        rsp_tdata;        // [0] found, [7:1] distance, [9:8] status, [17:10] depth

   int unsigned        fail_count;
   int unsigned        answers_owed;
   int unsigned        send_idle_pct  = 0;
   int unsigned        recv_stall_pct = 0;
   int unsigned        requests_sent  = 0;
   int unsigned        pushes_sent    = 0;
   int unsigned        cycle_count    = 0;

   // last few pushed keys, so finds hit often
   logic [sss_pkg::CLASS_W-1:0] recent_cls  [8];
   logic [sss_pkg::NAME_W-1:0]  recent_name [8];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   scoped_symbol_stack_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   scoped_symbol_stack_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .answers_owed (answers_owed)
   );

   // Response side back-pressure; stall rate set per phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: cycle limit hit with %0d responses outstanding", answers_owed);
         $display("tb: done, errors");
         $finish;
      end
   end

   // One request: optional idle gap, then hold tvalid until the handshake.
   // tvalid stays high across back-to-back requests (single NBA per edge).
   task automatic send_request(input logic [sss_pkg::OP_W-1:0] op,
                               input logic [sss_pkg::CLASS_W-1:0] cls,
                               input logic [sss_pkg::NAME_W-1:0] nm);
      int unsigned gaps;
      gaps = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gaps++;
      if (gaps != 0) begin
         req_tvalid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nm, cls, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (op == sss_pkg::OP_PUSH) begin
         recent_cls[pushes_sent % 8]  = cls;
         recent_name[pushes_sent % 8] = nm;
         pushes_sent++;
      end
   endtask

   // Key mix: a recent push, a tiny pool (lots of duplicates and shadowing),
   // or fully random bits.
   task automatic pick_key(output logic [sss_pkg::CLASS_W-1:0] cls,
                           output logic [sss_pkg::NAME_W-1:0] nm);
      int unsigned r;
      int unsigned idx;
      r = $urandom_range(0, 99);
      if (r < 35 && pushes_sent != 0) begin
         idx = $urandom_range(0, ((pushes_sent < 8) ? pushes_sent : 8) - 1);
         cls = recent_cls[idx];
         nm  = recent_name[idx];
      end else if (r < 70) begin
         cls = 8'($urandom_range(0, 3));
         nm  = $urandom_range(0, 3);
      end else begin
         cls = 8'($urandom);
         nm  = $urandom;
      end
   endtask

   // Close slightly outweighs open so the walk keeps returning to the base level.
   task automatic random_request();
      int unsigned                 r;
      logic [sss_pkg::OP_W-1:0]    op;
      logic [sss_pkg::CLASS_W-1:0] cls;
      logic [sss_pkg::NAME_W-1:0]  nm;
      r = $urandom_range(0, 99);
      if (r < 26)      op = sss_pkg::OP_PUSH;
      else if (r < 44) op = sss_pkg::OP_POP;
      else if (r < 53) op = sss_pkg::OP_OPEN;
      else if (r < 64) op = sss_pkg::OP_CLOSE;
      else if (r < 80) op = sss_pkg::OP_FIND;
      else if (r < 96) op = sss_pkg::OP_FIND_LEVEL;
      else if (r < 98) op = OP_SPARE_LO;
      else             op = OP_SPARE_HI;
      pick_key(cls, nm);
      send_request(op, cls, nm);
   endtask

   initial begin
      logic [sss_pkg::CLASS_W-1:0] first_cls;
      logic [sss_pkg::NAME_W-1:0]  first_name;
      logic [sss_pkg::CLASS_W-1:0] cls;
      logic [sss_pkg::NAME_W-1:0]  nm;
      int unsigned                 phase_end;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, no idling ----
      // empty stack: zero-span finds, pop of empty level, close of base level
      send_request(sss_pkg::OP_FIND,       8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_FIND_LEVEL, 8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_CLOSE,      8'h00, 32'h0000_0000);
      // field extremes
      send_request(sss_pkg::OP_PUSH,       8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_PUSH,       8'hFF, 32'hFFFF_FFFF);
      send_request(sss_pkg::OP_PUSH,       8'hA5, 32'h5A5A_5A5A);
      send_request(sss_pkg::OP_FIND,       8'h00, 32'h0000_0000);  // deepest, distance 2
      send_request(sss_pkg::OP_FIND,       8'hFF, 32'hFFFF_FFFF);
      send_request(sss_pkg::OP_FIND,       8'h00, 32'hFFFF_FFFF);  // class/name cross: miss
      // inner level: outer keys invisible to find-in-level, pop blocked
      send_request(sss_pkg::OP_OPEN,       8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_FIND_LEVEL, 8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_PUSH,       8'h5A, 32'hA5A5_A5A5);
      send_request(sss_pkg::OP_PUSH,       8'h00, 32'h0000_0000);  // shadows the outer copy
      send_request(sss_pkg::OP_FIND,       8'h00, 32'h0000_0000);  // nearest copy, distance 0
      send_request(sss_pkg::OP_FIND_LEVEL, 8'h5A, 32'hA5A5_A5A5);
      send_request(OP_SPARE_LO,            8'hFF, 32'hFFFF_FFFF);
      send_request(OP_SPARE_HI,            8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_CLOSE,      8'h00, 32'h0000_0000);  // discards the leftover key
      send_request(sss_pkg::OP_FIND,       8'h5A, 32'hA5A5_A5A5);  // gone after close
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);
      send_request(sss_pkg::OP_POP,        8'h00, 32'h0000_0000);  // base level empty again

      // ---- random part, four idling phases ----
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 54;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 54;
            end
            default: begin
               send_idle_pct  = 28;
               recv_stall_pct = 28;
            end
         endcase
         phase_end = requests_sent + PHASE_REQUESTS;

         if (phase == 1) begin
            // Fill to full inside a fresh level (130 pushes always overflow),
            // search the whole depth, then let the close drain it.
            send_request(sss_pkg::OP_OPEN, 8'h00, 32'h0000_0000);
            pick_key(first_cls, first_name);
            send_request(sss_pkg::OP_PUSH, first_cls, first_name);
            repeat (129) begin
               pick_key(cls, nm);
               send_request(sss_pkg::OP_PUSH, cls, nm);
            end
            send_request(sss_pkg::OP_FIND, first_cls, first_name);
            send_request(sss_pkg::OP_FIND, ~first_cls, first_name);  // likely full-depth miss
            pick_key(cls, nm);
            send_request(sss_pkg::OP_FIND_LEVEL, cls, nm);
            send_request(sss_pkg::OP_CLOSE, 8'h00, 32'h0000_0000);
         end

         if (phase == 3) begin
            // Level ladder: open past the top level, then close past the base.
            repeat (66) begin
               send_request(sss_pkg::OP_OPEN, 8'h00, 32'h0000_0000);
               if ($urandom_range(0, 3) == 0) begin
                  pick_key(cls, nm);
                  send_request(sss_pkg::OP_PUSH, cls, nm);
               end
            end
            pick_key(cls, nm);
            send_request(sss_pkg::OP_FIND_LEVEL, cls, nm);
            pick_key(cls, nm);
            send_request(sss_pkg::OP_FIND, cls, nm);
            repeat (67) send_request(sss_pkg::OP_CLOSE, 8'h00, 32'h0000_0000);
         end

         while (requests_sent < phase_end) random_request();
      end

      // ---- drain and verdict ----
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (answers_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && answers_owed == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
